[hw/rtl/sdsr_pkg.sv]
// SD card SPI responder: shared types and constants.
// No dependencies; imported by the interfaces, the queue and the top level.
`timescale 1ns / 1ps

package sdsr_pkg;

  localparam int unsigned SECTOR_BYTES = 512;
  localparam int unsigned SECTOR_AW    = 9;

  // configuration register indexes
  localparam int unsigned CFG_IW = 1;
  localparam int unsigned CFG_DW = 21;
  localparam logic [CFG_IW-1:0] REG_CARD_PRESENT = 1'd0;
  localparam logic [CFG_IW-1:0] REG_IMAGE_BYTES  = 1'd1;

  // command indexes
  localparam logic [5:0] CMD_GO_IDLE      = 6'd0;
  localparam logic [5:0] CMD_SEND_IF_COND = 6'd8;
  localparam logic [5:0] CMD_STATUS       = 6'd13;
  localparam logic [5:0] CMD_READ_BLOCK   = 6'd17;
  localparam logic [5:0] CMD_WRITE_BLOCK  = 6'd24;
  localparam logic [5:0] ACMD_OP_COND     = 6'd41;
  localparam logic [5:0] CMD_APP          = 6'd55;
  localparam logic [5:0] CMD_READ_OCR     = 6'd58;

  // response and token bytes
  localparam logic [7:0] R1_READY      = 8'h00;
  localparam logic [7:0] R1_IDLE       = 8'h01;
  localparam logic [7:0] R1_ILLEGAL    = 8'h04;
  localparam logic [7:0] R1_CRC_ERR    = 8'h09;
  localparam logic [7:0] DATA_ACCEPTED = 8'h05;
  localparam logic [7:0] TOKEN_START   = 8'hFE;
  localparam logic [7:0] FILL_BYTE     = 8'hFF;
  localparam logic [7:0] ZERO_BYTE     = 8'h00;
  localparam logic [7:0] CMD0_CRC      = 8'h95;
  localparam logic [7:0] CHECK_PATTERN = 8'hAA;
  localparam logic [7:0] IF_COND_VHS   = 8'h01;
  localparam logic [7:0] OCR_HI        = 8'h40;
  localparam logic [7:0] OCR_MID       = 8'h80;

  localparam logic [9:0] WAKE_MIN = 10'd74;
  localparam logic [9:0] WAKE_MAX = 10'd1000;

  // receive modes
  localparam logic [1:0] MODE_CMD   = 2'd0;
  localparam logic [1:0] MODE_TOKEN = 2'd1;
  localparam logic [1:0] MODE_DATA  = 2'd2;
  localparam logic [1:0] MODE_CRC   = 2'd3;

  typedef struct packed {
    logic flush;
    logic pop;
    logic push;
    logic rd_en;
  } sdsr_qctl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } sdsr_qstat_t;

endpackage

[hw/rtl/sdsr_if.sv]
// SD card SPI responder: channel interfaces (pin samples, results, register writes).
// Depends on sdsr_pkg.
`timescale 1ns / 1ps

interface sdsr_req_if;
  logic valid;
  logic ready;
  logic chip_select_n;
  logic serial_clock;
  logic host_data;
  logic clear_written;

  modport source (output valid, chip_select_n, serial_clock, host_data, clear_written,
                  input ready);
  modport sink   (input valid, chip_select_n, serial_clock, host_data, clear_written,
                  output ready);
endinterface

interface sdsr_rsp_if;
  logic valid;
  logic ready;
  logic card_data;
  logic written;

  modport source (output valid, card_data, written, input ready);
  modport sink   (input valid, card_data, written, output ready);
endinterface

interface sdsr_cfg_if;
  import sdsr_pkg::*;
  logic              valid;
  logic              ready;
  logic [CFG_IW-1:0] index;
  logic [CFG_DW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[hw/rtl/sdsr_queue.sv]
// SD card SPI responder: response byte queue, one RAM with registered head read.
// Depends on sdsr_pkg. Pushes into a full queue are dropped.
`timescale 1ns / 1ps

module sdsr_queue #(
  parameter int unsigned DEPTH = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sdsr_pkg::sdsr_qctl_t  ctl_i,
  input  logic [7:0]            push_data_i,
  output logic [7:0]            head_data_o,
  output sdsr_pkg::sdsr_qstat_t stat_o
);
  import sdsr_pkg::*;

  localparam int unsigned QW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [QW-1:0] LAST = QW'(DEPTH - 1);

  logic [7:0]    mem [DEPTH];
  logic [QW-1:0] head_q, head_d, tail_q, tail_d;
  logic [CW-1:0] count_q, count_d;
  logic [7:0]    rdata_q;
  logic          push_ok, pop_ok;

  assign stat_o.empty = (count_q == '0);
  assign stat_o.full  = (count_q == CW'(DEPTH));
  assign push_ok      = ctl_i.push && !stat_o.full && !ctl_i.flush;
  assign pop_ok       = ctl_i.pop && !stat_o.empty && !ctl_i.flush;
  assign head_data_o  = rdata_q;

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (ctl_i.flush) begin
      head_d  = '0;
      tail_d  = '0;
      count_d = '0;
    end else begin
      if (pop_ok) begin
        head_d = (head_q == LAST) ? '0 : head_q + 1'b1;
      end
      if (push_ok) begin
        tail_d = (tail_q == LAST) ? '0 : tail_q + 1'b1;
      end
      count_d = count_q + CW'(push_ok) - CW'(pop_ok);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem[tail_q] <= push_data_i;
    end
    if (ctl_i.rd_en) begin
      rdata_q <= mem[head_q];
    end
  end

endmodule

[hw/rtl/sd_card_spi_responder_core.sv]
// SD card SPI responder top level: pin sampling, command framing, sector store.
// Depends on sdsr_pkg, the interfaces in sdsr_if.sv and sdsr_queue.
`timescale 1ns / 1ps

// Usage:
//  req_i carries one sample of chip select, SPI clock, MOSI and a clear of the
//  written flag per request; rsp_o returns the MISO level and the written flag,
//  one result per request. cfg_i writes card_present (index 0) and image_bytes
//  (index 1); it is always ready and should only be used while the block idles.
//  Timing: an accepted request is latched, run in the EXEC state and its
//  result registered. The last bit of a byte that finishes a command adds the
//  reply bytes pushed into the response queue, one per cycle (1 for an R1,
//  5 for CMD8/CMD58); a CMD17 adds an R1, the start token, the sector copy out
//  of the image RAM and two fill bytes, and the end of a sector write adds the
//  copy from the sector buffer (when the sector fits) plus BUSY_BYTES + 2 pushes.
//  Every extra cycle comes from the single write port of the queue or image RAM.
//  Reset: the image RAM is zeroed, one byte per cycle, before the first
//  request is accepted.
//  A stalled rsp_o holds its result and blocks new requests until taken.
module sd_card_spi_responder_core #(
  parameter int unsigned IMAGE_SECTORS = 2048,
  parameter int unsigned QUEUE_DEPTH   = 1024,
  parameter int unsigned BUSY_BYTES    = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  sdsr_req_if.sink   req_i,
  sdsr_rsp_if.source rsp_o,
  sdsr_cfg_if.sink   cfg_i
);
  import sdsr_pkg::*;

  localparam int unsigned STORE = IMAGE_SECTORS * SECTOR_BYTES;
  localparam int unsigned AW    = $clog2(STORE);
  localparam logic [AW-1:0] STORE_LAST = AW'(STORE - 1);
  localparam int unsigned PW    = $clog2(BUSY_BYTES + 6);
  localparam logic [PW-1:0] WDONE_LAST = PW'(BUSY_BYTES + 1);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_EXEC  = 3'd2;
  localparam logic [2:0] ST_PUSH  = 3'd3;
  localparam logic [2:0] ST_SEC   = 3'd4;
  localparam logic [2:0] ST_WCOPY = 3'd5;

  localparam logic [2:0] K_ONE    = 3'd0;
  localparam logic [2:0] K_CMD8   = 3'd1;
  localparam logic [2:0] K_CMD58  = 3'd2;
  localparam logic [2:0] K_RDHEAD = 3'd3;
  localparam logic [2:0] K_RDTAIL = 3'd4;
  localparam logic [2:0] K_WDONE  = 3'd5;

  // memories
  logic [7:0] img_mem [STORE];
  logic [7:0] sbuf_mem [SECTOR_BYTES];
  logic [7:0] img_rdata_q, sbuf_rdata_q;
  logic          img_we;
  logic [AW-1:0] img_waddr, img_raddr;
  logic [7:0]    img_wdata;
  logic          sbuf_we;

  // control state
  logic [2:0]  state_q, state_d;
  logic        present_q;
  logic [CFG_DW-1:0] img_bytes_q;
  logic        last_clk_q, last_clk_d, last_sel_q, last_sel_d;
  logic [2:0]  bitpos_q, bitpos_d;
  logic [7:0]  out_byte_q, out_byte_d, in_byte_q, in_byte_d;
  logic        held_q, held_d;
  logic [1:0]  mode_q, mode_d;
  logic [7:0]  cmd_q [5];
  logic        cmd_wr;
  logic [2:0]  cmd_fill_q, cmd_fill_d;
  logic [31:0] target_q, target_d, xfer_q, xfer_d;
  logic [8:0]  sfill_q, sfill_d;
  logic [1:0]  crc_left_q, crc_left_d, left_n;
  logic        app_q, app_d, idle_q, idle_d, ready_q, ready_d;
  logic [1:0]  tries_q, tries_d;
  logic [9:0]  wake_q, wake_d;
  logic        written_q, written_d;
  logic        rsp_valid_q, rsp_valid_d;
  logic        card_data_q, card_data_d;
  logic [2:0]  kind_q, kind_d;
  logic [PW-1:0] pidx_q, pidx_d, plast;
  logic [7:0]  one_q, one_d, push_byte;
  logic [9:0]  sec_cnt_q, sec_cnt_d, wcnt_q, wcnt_d;
  logic        sec_pend_q, sec_pend_d, sec_inr_q, sec_inr_d;
  logic        wpend_q, wpend_d;
  logic [8:0]  wlow_q, wlow_d;
  logic [AW-1:0] clr_cnt_q, clr_cnt_d;

  // latched request payload
  logic cs_q, sck_q, mosi_q, clrw_q;

  // datapath helpers
  logic        req_ready, rise, done, fits;
  logic [7:0]  ob, rx, r1;
  logic [5:0]  cmd_idx;
  logic [31:0] arg;
  logic [40:0] lim41, sec_addr, w_full;
  logic [41:0] fit_end;

  sdsr_qctl_t  qctl;
  sdsr_qstat_t qstat;
  logic [7:0]  q_wdata, q_head;

  sdsr_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (qctl),
    .push_data_i (q_wdata),
    .head_data_o (q_head),
    .stat_o      (qstat)
  );

  assign req_ready       = (state_q == ST_IDLE) && (!rsp_valid_q || rsp_o.ready);
  assign req_i.ready     = req_ready;
  assign rsp_o.valid     = rsp_valid_q;
  assign rsp_o.card_data = card_data_q;
  assign rsp_o.written   = written_q;
  assign cfg_i.ready     = 1'b1;

  // bytes past the image size (capped at the store) read as zero
  assign lim41    = (41'(img_bytes_q) > 41'(STORE)) ? 41'(STORE) : 41'(img_bytes_q);
  assign sec_addr = {xfer_q, sec_cnt_q[8:0]};
  assign img_raddr = sec_addr[AW-1:0];
  assign w_full   = {target_q, wlow_q};
  assign fit_end  = {({1'b0, target_q} + 33'd1), 9'd0};
  assign fits     = fit_end <= 42'(lim41);
  assign cmd_idx  = cmd_q[0][5:0];
  assign arg      = {cmd_q[1], cmd_q[2], cmd_q[3], cmd_q[4]};

  always_comb begin
    case (kind_q)
      K_CMD8:   plast = PW'(4);
      K_CMD58:  plast = PW'(4);
      K_RDHEAD: plast = PW'(1);
      K_RDTAIL: plast = PW'(1);
      K_WDONE:  plast = WDONE_LAST;
      default:  plast = '0;
    endcase
  end

  always_comb begin
    push_byte = one_q;
    case (kind_q)
      K_CMD8: begin
        case (pidx_q[2:0])
          3'd0:    push_byte = one_q;
          3'd3:    push_byte = IF_COND_VHS;
          3'd4:    push_byte = CHECK_PATTERN;
          default: push_byte = ZERO_BYTE;
        endcase
      end
      K_CMD58: begin
        case (pidx_q[2:0])
          3'd0:    push_byte = one_q;
          3'd1:    push_byte = OCR_HI;
          3'd2:    push_byte = FILL_BYTE;
          3'd3:    push_byte = OCR_MID;
          default: push_byte = ZERO_BYTE;
        endcase
      end
      K_RDHEAD: push_byte = (pidx_q == '0) ? one_q : TOKEN_START;
      K_RDTAIL: push_byte = FILL_BYTE;
      K_WDONE: begin
        if (pidx_q == '0) begin
          push_byte = DATA_ACCEPTED;
        end else if (pidx_q == WDONE_LAST) begin
          push_byte = FILL_BYTE;
        end else begin
          push_byte = ZERO_BYTE;
        end
      end
      default: push_byte = one_q;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    last_clk_d  = last_clk_q;
    last_sel_d  = last_sel_q;
    bitpos_d    = bitpos_q;
    out_byte_d  = out_byte_q;
    in_byte_d   = in_byte_q;
    held_d      = held_q;
    mode_d      = mode_q;
    cmd_fill_d  = cmd_fill_q;
    target_d    = target_q;
    xfer_d      = xfer_q;
    sfill_d     = sfill_q;
    crc_left_d  = crc_left_q;
    app_d       = app_q;
    idle_d      = idle_q;
    ready_d     = ready_q;
    tries_d     = tries_q;
    wake_d      = wake_q;
    written_d   = written_q;
    rsp_valid_d = rsp_valid_q && !rsp_o.ready;
    card_data_d = card_data_q;
    kind_d      = kind_q;
    pidx_d      = pidx_q;
    one_d       = one_q;
    sec_cnt_d   = sec_cnt_q;
    sec_pend_d  = 1'b0;
    sec_inr_d   = sec_inr_q;
    wcnt_d      = wcnt_q;
    wpend_d     = 1'b0;
    wlow_d      = wlow_q;
    clr_cnt_d   = clr_cnt_q;
    qctl        = '0;
    q_wdata     = push_byte;
    img_we      = 1'b0;
    img_waddr   = w_full[AW-1:0];
    img_wdata   = sbuf_rdata_q;
    sbuf_we     = 1'b0;
    cmd_wr      = 1'b0;
    rise        = 1'b0;
    ob          = out_byte_q;
    rx          = {in_byte_q[6:0], mosi_q};
    r1          = R1_ILLEGAL;
    done        = 1'b0;
    left_n      = '0;

    unique case (state_q)
      ST_CLEAR: begin
        img_we    = 1'b1;
        img_waddr = clr_cnt_q;
        img_wdata = ZERO_BYTE;
        if (clr_cnt_q == STORE_LAST) begin
          state_d = ST_IDLE;
        end else begin
          clr_cnt_d = clr_cnt_q + 1'b1;
        end
      end

      ST_IDLE: begin
        if (req_i.valid && req_ready) begin
          qctl.rd_en = 1'b1;
          state_d    = ST_EXEC;
        end
      end

      ST_EXEC: begin
        state_d     = ST_IDLE;
        rsp_valid_d = 1'b1;
        card_data_d = 1'b1;
        if (clrw_q) begin
          written_d = 1'b0;
        end
        if (present_q) begin
          rise       = sck_q && !last_clk_q;
          last_clk_d = sck_q;
          last_sel_d = cs_q;
          if (cs_q) begin
            if (!last_sel_q) begin
              mode_d     = MODE_CMD;
              cmd_fill_d = '0;
              qctl.flush = 1'b1;
            end
            if (rise && (wake_q < WAKE_MAX)) begin
              wake_d = wake_q + 1'b1;
            end
            bitpos_d = '0;
            held_d   = 1'b1;
          end else if (rise) begin
            if (bitpos_q == '0) begin
              qctl.pop   = 1'b1;
              ob         = qstat.empty ? FILL_BYTE : q_head;
              out_byte_d = ob;
            end
            in_byte_d   = rx;
            held_d      = ob[3'd7 - bitpos_q];
            card_data_d = ob[3'd7 - bitpos_q];
            bitpos_d    = bitpos_q + 1'b1;
            if (bitpos_q == 3'd7) begin
              unique case (mode_q)
                MODE_CMD: begin
                  if (!((cmd_fill_q == '0) && (rx == FILL_BYTE))) begin
                    if (cmd_fill_q == 3'd5) begin
                      cmd_fill_d = '0;
                      pidx_d     = '0;
                      kind_d     = K_ONE;
                      if ((cmd_idx == CMD_GO_IDLE) && (wake_q < WAKE_MIN)) begin
                        // reset command before enough wake clocks: ignored
                        kind_d = K_ONE;
                      end else if (((cmd_idx == CMD_GO_IDLE) && (rx != CMD0_CRC)) ||
                                   (rx == ZERO_BYTE)) begin
                        one_d   = R1_CRC_ERR;
                        state_d = ST_PUSH;
                      end else begin
                        if (cmd_idx == CMD_APP) begin
                          app_d = 1'b1;
                          r1    = idle_q ? R1_IDLE : R1_READY;
                          done  = 1'b1;
                        end else if (app_q) begin
                          app_d = 1'b0;
                          if (cmd_idx == ACMD_OP_COND) begin
                            done = 1'b1;
                            if (tries_q != '0) begin
                              tries_d = 2'd2;
                              ready_d = 1'b1;
                              idle_d  = 1'b0;
                              r1      = R1_READY;
                            end else begin
                              tries_d = 2'd1;
                              r1      = R1_IDLE;
                            end
                          end
                        end
                        if (!done) begin
                          case (cmd_idx) inside
                            CMD_GO_IDLE, CMD_SEND_IF_COND: r1 = R1_IDLE;
                            CMD_READ_OCR, CMD_STATUS:      r1 = R1_READY;
                            CMD_READ_BLOCK, CMD_WRITE_BLOCK:
                              r1 = ready_q ? R1_READY : R1_IDLE;
                            default:                       r1 = R1_ILLEGAL;
                          endcase
                        end
                        one_d   = r1;
                        state_d = ST_PUSH;
                        if (cmd_idx == CMD_SEND_IF_COND) begin
                          kind_d = K_CMD8;
                        end else if (cmd_idx == CMD_READ_OCR) begin
                          kind_d = K_CMD58;
                        end else if ((cmd_idx == CMD_READ_BLOCK) && (r1 == R1_READY)) begin
                          kind_d = K_RDHEAD;
                          xfer_d = arg;
                        end else if ((cmd_idx == CMD_WRITE_BLOCK) && (r1 == R1_READY)) begin
                          target_d = arg;
                          mode_d   = MODE_TOKEN;
                        end
                        if (cmd_idx == CMD_GO_IDLE) begin
                          idle_d  = 1'b1;
                          ready_d = 1'b0;
                          tries_d = '0;
                        end
                      end
                    end else begin
                      cmd_wr     = 1'b1;
                      cmd_fill_d = cmd_fill_q + 1'b1;
                    end
                  end
                end
                MODE_TOKEN: begin
                  if (rx == TOKEN_START) begin
                    mode_d  = MODE_DATA;
                    sfill_d = '0;
                  end
                end
                MODE_DATA: begin
                  sbuf_we = 1'b1;
                  sfill_d = sfill_q + 1'b1;
                  if (sfill_q == 9'(SECTOR_BYTES - 1)) begin
                    mode_d     = MODE_CRC;
                    crc_left_d = 2'd2;
                  end
                end
                MODE_CRC: begin
                  left_n     = (crc_left_q != '0) ? crc_left_q - 1'b1 : '0;
                  crc_left_d = left_n;
                  if (left_n == '0) begin
                    written_d = 1'b1;
                    mode_d    = MODE_CMD;
                    kind_d    = K_WDONE;
                    pidx_d    = '0;
                    wcnt_d    = '0;
                    // a sector that does not fit is dropped but still answered
                    state_d   = fits ? ST_WCOPY : ST_PUSH;
                  end
                end
                default: mode_d = MODE_CMD;
              endcase
            end
          end else begin
            card_data_d = held_q;
          end
        end
      end

      ST_PUSH: begin
        qctl.push = 1'b1;
        q_wdata   = push_byte;
        if (pidx_q == plast) begin
          if (kind_q == K_RDHEAD) begin
            state_d   = ST_SEC;
            sec_cnt_d = '0;
          end else begin
            state_d = ST_IDLE;
          end
        end else begin
          pidx_d = pidx_q + 1'b1;
        end
      end

      ST_SEC: begin
        // image read issued in the cycle before its push
        sec_pend_d = !sec_cnt_q[9];
        sec_inr_d  = sec_addr < lim41;
        if (!sec_cnt_q[9]) begin
          sec_cnt_d = sec_cnt_q + 1'b1;
        end else begin
          state_d = ST_PUSH;
          kind_d  = K_RDTAIL;
          pidx_d  = '0;
        end
        if (sec_pend_q) begin
          qctl.push = 1'b1;
          q_wdata   = sec_inr_q ? img_rdata_q : ZERO_BYTE;
        end
      end

      ST_WCOPY: begin
        wpend_d = !wcnt_q[9];
        wlow_d  = wcnt_q[8:0];
        if (!wcnt_q[9]) begin
          wcnt_d = wcnt_q + 1'b1;
        end else begin
          state_d = ST_PUSH;
        end
        if (wpend_q) begin
          img_we    = 1'b1;
          img_waddr = w_full[AW-1:0];
          img_wdata = sbuf_rdata_q;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      present_q   <= 1'b0;
      img_bytes_q <= '0;
      last_clk_q  <= 1'b0;
      last_sel_q  <= 1'b1;
      bitpos_q    <= '0;
      out_byte_q  <= FILL_BYTE;
      in_byte_q   <= '0;
      held_q      <= 1'b1;
      mode_q      <= MODE_CMD;
      cmd_fill_q  <= '0;
      target_q    <= '0;
      xfer_q      <= '0;
      sfill_q     <= '0;
      crc_left_q  <= '0;
      app_q       <= 1'b0;
      idle_q      <= 1'b1;
      ready_q     <= 1'b0;
      tries_q     <= '0;
      wake_q      <= '0;
      written_q   <= 1'b0;
      rsp_valid_q <= 1'b0;
      kind_q      <= K_ONE;
      pidx_q      <= '0;
      sec_cnt_q   <= '0;
      sec_pend_q  <= 1'b0;
      wcnt_q      <= '0;
      wpend_q     <= 1'b0;
      clr_cnt_q   <= '0;
    end else begin
      if (cfg_i.valid) begin
        unique case (cfg_i.index)
          REG_CARD_PRESENT: present_q   <= cfg_i.data[0];
          REG_IMAGE_BYTES:  img_bytes_q <= cfg_i.data;
          default:          present_q   <= present_q;
        endcase
      end
      state_q     <= state_d;
      last_clk_q  <= last_clk_d;
      last_sel_q  <= last_sel_d;
      bitpos_q    <= bitpos_d;
      out_byte_q  <= out_byte_d;
      in_byte_q   <= in_byte_d;
      held_q      <= held_d;
      mode_q      <= mode_d;
      cmd_fill_q  <= cmd_fill_d;
      target_q    <= target_d;
      xfer_q      <= xfer_d;
      sfill_q     <= sfill_d;
      crc_left_q  <= crc_left_d;
      app_q       <= app_d;
      idle_q      <= idle_d;
      ready_q     <= ready_d;
      tries_q     <= tries_d;
      wake_q      <= wake_d;
      written_q   <= written_d;
      rsp_valid_q <= rsp_valid_d;
      kind_q      <= kind_d;
      pidx_q      <= pidx_d;
      sec_cnt_q   <= sec_cnt_d;
      sec_pend_q  <= sec_pend_d;
      wcnt_q      <= wcnt_d;
      wpend_q     <= wpend_d;
      clr_cnt_q   <= clr_cnt_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_ready) begin
      cs_q   <= req_i.chip_select_n;
      sck_q  <= req_i.serial_clock;
      mosi_q <= req_i.host_data;
      clrw_q <= req_i.clear_written;
    end
    if (cmd_wr) begin
      cmd_q[cmd_fill_q] <= in_byte_d;
    end
    card_data_q <= card_data_d;
    one_q       <= one_d;
    sec_inr_q   <= sec_inr_d;
    wlow_q      <= wlow_d;
  end

  // image RAM: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (img_we) begin
      img_mem[img_waddr] <= img_wdata;
    end
    img_rdata_q <= img_mem[img_raddr];
  end

  // sector buffer: written from the data phase, read by the copy
  always_ff @(posedge clk_i) begin
    if (sbuf_we) begin
      sbuf_mem[sfill_q] <= in_byte_d;
    end
    sbuf_rdata_q <= sbuf_mem[wcnt_q[8:0]];
  end

  a_exec_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EXEC |=> rsp_o.valid)
    else $error("no result after request execution");

  a_accept_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> state_q == ST_EXEC)
    else $error("accepted request not executed");

  a_written_from_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(written_q) |-> $past(state_q) == ST_EXEC)
    else $error("written flag set outside request execution");

  a_image_write_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    img_we |-> (state_q == ST_CLEAR || (state_q == ST_WCOPY && wpend_q)))
    else $error("image write outside clear or sector copy");

endmodule
